// File: rtl/core/rtdp_pkg.sv
// shared types and constants of the rtd potentiometer step pipeline
package rtdp_pkg;

  // operation codes
  localparam logic [1:0] OP_RAW  = 2'd0;
  localparam logic [1:0] OP_RES  = 2'd1;
  localparam logic [1:0] OP_TEMP = 2'd2;

  // clamp status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ADDR = 2'd0;
  localparam logic [1:0] REG_FULL = 2'd1;
  localparam logic [1:0] REG_W0   = 2'd2;
  localparam logic [1:0] REG_W1   = 2'd3;

  // working widths: signed resistance count, full scale count, dividend
  localparam int NW = 101;
  localparam int DW = 100;
  localparam int XW = 110;

  // curve coefficients, resistance in units of 1e-10 milliohm, cubic term in 1e-21
  localparam logic [35:0] K_LIN   = 36'd39083000000;
  localparam logic [12:0] K_QUAD  = 13'd5775;
  localparam logic [12:0] K_CUB   = 13'd4183;
  localparam logic [20:0] K_OFF   = 21'd100000;
  localparam logic [57:0] K_R0    = 58'd10000000000000000;
  localparam logic [36:0] K_SCALE = 37'd100000000000;
  localparam logic [39:0] K_E12   = 40'd1000000000000;
  localparam logic [9:0]  K_MILLI = 10'd1000;

  typedef struct packed {
    logic       rej;
    logic [1:0] op;
    logic       ch1;
    logic [7:0] raw;
  } ctl_t;

endpackage

// File: rtl/core/rtd_temperature_to_pot_step.sv
// pt1000 / resistance to potentiometer wiper frame pipeline
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid/in_ready   | operation, channel, raw_step, resistance,
//          |                     | temperature
//  out     | out_valid/out_ready | rejected, bus_address, command_byte,
//          |                     | step_value, clamp_status
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// one beat per cycle in and out while out_ready allows; the pipeline has five
// curve stages, a clamp stage, then one restoring divide stage per
// quotient bit. each stage has its own valid bit and loads when it is empty or
// the stage after it can take its beat, so bubbles close up under a stall.
// synchronous active-low reset clears valid bits and loads config register defaults.
module rtd_temperature_to_pot_step #(
  parameter int STEP_MAX = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_channel,
  input  logic [7:0]         in_raw_step,
  input  logic signed [30:0] in_resistance_milliohms,
  input  logic signed [20:0] in_temperature_millicelsius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_rejected,
  output logic [6:0]         out_bus_address,
  output logic [7:0]         out_command_byte,
  output logic [7:0]         out_step_value,
  output logic [1:0]         out_clamp_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int QB = $clog2(STEP_MAX + 1);
  localparam int NS = 6 + QB;
  localparam logic [9:0] K_TWICE = 10'(2 * STEP_MAX);

  // config registers
  logic [6:0]  addr_r;
  logic [19:0] full_r;
  logic [7:0]  w0_r, w1_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= 7'd44;
      full_r <= 20'd10000;
      w0_r   <= 8'd0;
      w1_r   <= 8'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtdp_pkg::REG_ADDR: addr_r <= cfg_data[6:0];
        rtdp_pkg::REG_FULL: full_r <= cfg_data;
        rtdp_pkg::REG_W0:   w0_r   <= cfg_data[7:0];
        rtdp_pkg::REG_W1:   w1_r   <= cfg_data[7:0];
      endcase
    end
  end

  // valid chain and per-stage ready
  logic [NS:1] v_r;
  logic [NS:1] rdy;

  always_comb begin
    rdy[NS] = !v_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) if (rdy[k]) v_r[k] <= v_r[k-1];
    end
  end

  // stage 1: magnitude, square, linear term, full scale products
  rtdp_pkg::ctl_t     ctl_nxt;
  logic               neg_nxt;
  logic [20:0]        t_nxt;
  logic [19:0]        full1;

  always_comb begin
    ctl_nxt.rej = (in_channel > 8'd1) || (in_operation == 2'd3);
    ctl_nxt.op  = in_operation;
    ctl_nxt.ch1 = in_channel[0];
    ctl_nxt.raw = in_raw_step;
    neg_nxt     = in_temperature_millicelsius[20];
    t_nxt       = neg_nxt ? 21'(-in_temperature_millicelsius)
                          : 21'(in_temperature_millicelsius);
    full1       = (full_r == 20'd0) ? 20'd1 : full_r;
  end

  rtdp_pkg::ctl_t     s1_ctl_r;
  logic               s1_neg_r;
  logic [20:0]        s1_t_r;
  logic [41:0]        s1_sq_r;
  logic [32:0]        s1_u_r;
  logic [56:0]        s1_lin_r;
  logic signed [30:0] s1_r_r;
  logic [29:0]        s1_dr_r;
  logic [59:0]        s1_f1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_ctl_r <= ctl_nxt;
      s1_neg_r <= neg_nxt;
      s1_t_r   <= t_nxt;
      s1_sq_r  <= 42'(t_nxt) * 42'(t_nxt);
      s1_u_r   <= (33'(t_nxt) + 33'(rtdp_pkg::K_OFF)) * 33'(rtdp_pkg::K_CUB);
      s1_lin_r <= 57'(t_nxt) * 57'(rtdp_pkg::K_LIN);
      s1_r_r   <= in_resistance_milliohms;
      s1_dr_r  <= 30'(full1) * 30'(rtdp_pkg::K_MILLI);
      s1_f1_r  <= 60'(full1) * 60'(rtdp_pkg::K_E12);
    end
  end

  // stage 2: quadratic term, quartic partial, full scale halves
  rtdp_pkg::ctl_t     s2_ctl_r;
  logic               s2_neg_r;
  logic [41:0]        s2_sq_r;
  logic [56:0]        s2_lin_r;
  logic [54:0]        s2_m_r;
  logic [53:0]        s2_ut_r;
  logic signed [30:0] s2_r_r;
  logic [29:0]        s2_dr_r;
  logic [69:0]        s2_fh_r, s2_fl_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_ctl_r <= s1_ctl_r;
      s2_neg_r <= s1_neg_r;
      s2_sq_r  <= s1_sq_r;
      s2_lin_r <= s1_lin_r;
      s2_m_r   <= 55'(s1_sq_r) * 55'(rtdp_pkg::K_QUAD);
      s2_ut_r  <= 54'(s1_u_r) * 54'(s1_t_r);
      s2_r_r   <= s1_r_r;
      s2_dr_r  <= s1_dr_r;
      s2_fh_r  <= 70'(s1_f1_r[59:30]) * 70'(rtdp_pkg::K_E12);
      s2_fl_r  <= 70'(s1_f1_r[29:0]) * 70'(rtdp_pkg::K_E12);
    end
  end

  // stage 3: low order polynomial, quartic halves, full scale sum
  logic signed [57:0] p_nxt;

  always_comb begin
    if (s2_neg_r) p_nxt = $signed(rtdp_pkg::K_R0) - $signed(58'(s2_lin_r));
    else          p_nxt = $signed(rtdp_pkg::K_R0) + $signed(58'(s2_lin_r));
    p_nxt = p_nxt - $signed(58'(s2_m_r));
  end

  rtdp_pkg::ctl_t     s3_ctl_r;
  logic               s3_neg_r;
  logic signed [57:0] s3_p_r;
  logic [68:0]        s3_qh_r, s3_ql_r;
  logic [rtdp_pkg::DW-1:0] s3_f_r;
  logic signed [30:0] s3_r_r;
  logic [29:0]        s3_dr_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_ctl_r <= s2_ctl_r;
      s3_neg_r <= s2_neg_r;
      s3_p_r   <= p_nxt;
      s3_qh_r  <= 69'(s2_sq_r) * 69'(s2_ut_r[53:27]);
      s3_ql_r  <= 69'(s2_sq_r) * 69'(s2_ut_r[26:0]);
      s3_f_r   <= (rtdp_pkg::DW'(s2_fh_r) << 30) + rtdp_pkg::DW'(s2_fl_r);
      s3_r_r   <= s2_r_r;
      s3_dr_r  <= s2_dr_r;
    end
  end

  // stage 4: scale polynomial in two halves, sum quartic term
  logic signed [28:0] p_hi;
  assign p_hi = s3_p_r[57:29];

  rtdp_pkg::ctl_t     s4_ctl_r;
  logic               s4_neg_r;
  logic signed [66:0] s4_ph_r;
  logic [65:0]        s4_pl_r;
  logic [95:0]        s4_q_r;
  logic [rtdp_pkg::DW-1:0] s4_f_r;
  logic signed [30:0] s4_r_r;
  logic [29:0]        s4_dr_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_ctl_r <= s3_ctl_r;
      s4_neg_r <= s3_neg_r;
      s4_ph_r  <= 67'(p_hi) * $signed(67'(rtdp_pkg::K_SCALE));
      s4_pl_r  <= 66'(s3_p_r[28:0]) * 66'(rtdp_pkg::K_SCALE);
      s4_q_r   <= (96'(s3_qh_r) << 27) + 96'(s3_ql_r);
      s4_f_r   <= s3_f_r;
      s4_r_r   <= s3_r_r;
      s4_dr_r  <= s3_dr_r;
    end
  end

  // stage 5: pick numerator and full scale for the operation
  logic signed [rtdp_pkg::NW-1:0] n_nxt;
  logic [rtdp_pkg::DW-1:0]        d_nxt;

  always_comb begin
    if (s4_ctl_r.op == rtdp_pkg::OP_TEMP) begin
      n_nxt = (rtdp_pkg::NW'(s4_ph_r) <<< 29) + $signed(rtdp_pkg::NW'(s4_pl_r));
      if (s4_neg_r) n_nxt = n_nxt - $signed(rtdp_pkg::NW'(s4_q_r));
      d_nxt = s4_f_r;
    end else begin
      n_nxt = rtdp_pkg::NW'(s4_r_r);
      d_nxt = rtdp_pkg::DW'(s4_dr_r);
    end
  end

  rtdp_pkg::ctl_t                 s5_ctl_r;
  logic signed [rtdp_pkg::NW-1:0] s5_n_r;
  logic [rtdp_pkg::DW-1:0]        s5_d_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_ctl_r <= s4_ctl_r;
      s5_n_r   <= n_nxt;
      s5_d_r   <= d_nxt;
    end
  end

  // stage 6: clamp and dividend 2*STEP_MAX*N + D for round half up
  logic [1:0] st_nxt;

  always_comb begin
    priority if (s5_n_r[rtdp_pkg::NW-1])                    st_nxt = rtdp_pkg::ST_ZERO;
    else if (s5_n_r > $signed({1'b0, s5_d_r}))              st_nxt = rtdp_pkg::ST_FULL;
    else                                                    st_nxt = rtdp_pkg::ST_OK;
  end

  rtdp_pkg::ctl_t          dc_r [QB+1];
  logic [1:0]              ds_r [QB+1];
  logic [rtdp_pkg::XW-1:0] dx_r [QB+1];
  logic [rtdp_pkg::DW:0]   dd_r [QB+1];
  logic [7:0]              dq_r [QB+1];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      dc_r[0] <= s5_ctl_r;
      ds_r[0] <= st_nxt;
      dx_r[0] <= rtdp_pkg::XW'(s5_n_r[rtdp_pkg::DW-1:0]) * rtdp_pkg::XW'(K_TWICE)
               + rtdp_pkg::XW'(s5_d_r);
      dd_r[0] <= {s5_d_r, 1'b0};
      dq_r[0] <= 8'd0;
    end
  end

  // restoring divide, one quotient bit per stage, msb first
  for (genvar k = 1; k <= QB; k++) begin : g_div
    localparam int B = QB - k;
    logic [rtdp_pkg::XW-1:0] sub;
    logic                    fit;

    always_comb begin
      sub = rtdp_pkg::XW'(dd_r[k-1]) << B;
      fit = (sub <= dx_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (rdy[6+k]) begin
        dc_r[k] <= dc_r[k-1];
        ds_r[k] <= ds_r[k-1];
        dd_r[k] <= dd_r[k-1];
        dx_r[k] <= fit ? (dx_r[k-1] - sub) : dx_r[k-1];
        dq_r[k] <= dq_r[k-1] | (fit ? (8'd1 << B) : 8'd0);
      end
    end
  end

  // output beat
  rtdp_pkg::ctl_t oc;
  assign oc = dc_r[QB];

  always_comb begin
    out_valid        = v_r[NS];
    out_rejected     = oc.rej;
    out_bus_address  = 7'd0;
    out_command_byte = 8'd0;
    out_step_value   = 8'd0;
    out_clamp_status = rtdp_pkg::ST_OK;
    if (!oc.rej) begin
      out_bus_address  = addr_r;
      out_command_byte = oc.ch1 ? w1_r : w0_r;
      if (oc.op == rtdp_pkg::OP_RAW) begin
        out_step_value = oc.raw;
      end else begin
        out_clamp_status = ds_r[QB];
        unique case (ds_r[QB])
          rtdp_pkg::ST_ZERO: out_step_value = 8'd0;
          rtdp_pkg::ST_FULL: out_step_value = 8'(STEP_MAX);
          default:           out_step_value = dq_r[QB];
        endcase
      end
    end
  end

endmodule

// File: rtl/core/rtdp_chk.sv
// port-level checker for the rtd potentiometer step pipeline
module rtdp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_rejected,
  input logic [6:0] out_bus_address,
  input logic [7:0] out_command_byte,
  input logic [7:0] out_step_value,
  input logic [1:0] out_clamp_status
);

  // a rejected beat carries an empty frame
  a_rej_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_bus_address == 7'd0 &&
      out_command_byte == 8'd0 && out_step_value == 8'd0 &&
      out_clamp_status == rtdp_pkg::ST_OK)
    else $error("rejected beat with nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clamp_status != 2'd3)
    else $error("undefined clamp status");

  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamp_status == rtdp_pkg::ST_ZERO |-> out_step_value == 8'd0)
    else $error("clamp at zero with nonzero step");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_value))
    else $error("stalled beat changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rtd_temperature_to_pot_step rtdp_chk u_rtdp_chk (.*);
